@@ hdl/exsort_pkg.sv @@
// Shared types and constants for the descending exchange sorter.
package exsort_pkg;

    // Number of entries in one batch.
    localparam int ENTRY_COUNT = 10;
    // At most this many ranked results leave per batch.
    localparam int MAX_EMIT = 10;
    localparam int EMIT_COUNT = (ENTRY_COUNT < MAX_EMIT) ? ENTRY_COUNT : MAX_EMIT;

    // Field widths.
    localparam int SCORE_W = 16;
    localparam int NAME_W = 24;
    localparam int RANK_W = 4;
    localparam int ENTRY_W = SCORE_W + NAME_W;
    localparam int IDX_W = $clog2(ENTRY_COUNT);

    // Stream data widths, padded to whole bytes.
    localparam int S_DATA_W = ((ENTRY_W + 7) / 8) * 8;
    localparam int M_USED_W = RANK_W + ENTRY_W;
    localparam int M_DATA_W = ((M_USED_W + 7) / 8) * 8;

    // One stored entry: name in the upper bits, score in the lower bits.
    typedef struct packed {
        logic [NAME_W-1:0]         name;
        logic signed [SCORE_W-1:0] score;
    } entry_t;

endpackage

@@ hdl/exsort_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module exsort_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/exchange_sort_descending.sv @@
// Ranking table sorter: loads a batch, exchange-sorts it by descending score, emits ranks.
//
// Usage:
//   The slave stream (s_tvalid, s_tready, s_tdata) takes one entry per transaction,
//   a signed score and three name characters. After ENTRY_COUNT entries the block
//   sorts the batch in descending score order with a plain exchange sort (ties land
//   as that swap order leaves them) and sends the ranked entries on the master
//   stream (m_tvalid, m_tready, m_tdata, m_tlast). At most ten results leave per
//   batch; m_tlast marks the final one.
//   Sorting runs one compare-exchange per cycle, limited by the single read port
//   of the entry memory; the final slot needs no pass of its own. s_tready is low
//   from the last entry of a batch until its final result is in the output register.
//   A result waits in the output register while m_tready is low, and sorting
//   pauses at the next result until it is taken. Reset empties the batch and the
//   output register; the entry memory keeps its contents and is not cleared.
module exchange_sort_descending (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata from bit 0: score[15:0], name_chars[23:0].
    input  logic [exsort_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata from bit 0: rank[3:0], sorted_score[15:0], sorted_name[23:0], zero pad.
    output logic [exsort_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    localparam int IW = exsort_pkg::IDX_W;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    localparam logic [IW-1:0] LAST_IDX = IW'(exsort_pkg::ENTRY_COUNT - 1);
    localparam logic [IW-1:0] EMIT_LAST = IW'(exsort_pkg::EMIT_COUNT - 1);

    state_t                               state_reg, state_next;
    logic [IW-1:0]                        load_count_reg, load_count_next;
    logic [IW-1:0]                        i_reg, i_next;
    logic [IW-1:0]                        j_reg, j_next;
    logic                                 proc_valid_reg, proc_valid_next;
    logic [IW-1:0]                        proc_idx_reg, proc_idx_next;
    exsort_pkg::entry_t                   cur_reg, cur_next;
    exsort_pkg::entry_t                   nxt_reg, nxt_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [exsort_pkg::RANK_W-1:0]        out_rank_reg, out_rank_next;
    exsort_pkg::entry_t                   out_entry_reg, out_entry_next;
    logic                                 out_last_reg, out_last_next;

    // Memory port signals.
    logic                                 ram_wr_en;
    logic [IW-1:0]                        ram_wr_addr;
    exsort_pkg::entry_t                   ram_wr_data;
    logic                                 ram_rd_en;
    logic [IW-1:0]                        ram_rd_addr;
    logic [exsort_pkg::ENTRY_W-1:0]       ram_rd_raw;
    exsort_pkg::entry_t                   rd_entry;
    exsort_pkg::entry_t                   in_entry;
    logic                                 s_accept;
    logic                                 swap;
    logic                                 emit_ok;

    assign in_entry = exsort_pkg::entry_t'(s_tdata[exsort_pkg::ENTRY_W-1:0]);
    assign rd_entry = exsort_pkg::entry_t'(ram_rd_raw);
    assign s_tready = (state_reg == ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign emit_ok  = !out_valid_reg || m_tready;

    // Compare the entry read back with the entry held for slot i.
    assign swap = proc_valid_reg && (rd_entry.score > cur_reg.score);

    exsort_ram #(
        .WIDTH(exsort_pkg::ENTRY_W),
        .DEPTH(exsort_pkg::ENTRY_COUNT)
    ) u_store (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_raw)
    );

    // Control and datapath next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        proc_valid_next = 1'b0;
        proc_idx_next   = proc_idx_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_rank_next   = out_rank_reg;
        out_entry_next  = out_entry_reg;
        out_last_next   = out_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = proc_idx_reg;
        ram_wr_data     = cur_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = j_reg;

        // Finish a compare-exchange: the loser goes back to its slot.
        if (proc_valid_reg)
        begin
            if (swap)
            begin
                ram_wr_en = 1'b1;
                cur_next  = rd_entry;
            end
            // Keep the settled value of slot i+1 for the next pass.
            if (proc_idx_reg == i_reg + 1'b1)
            begin
                nxt_next = swap ? cur_reg : rd_entry;
            end
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (s_accept)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = load_count_reg;
                    ram_wr_data = in_entry;
                    if (load_count_reg == '0)
                    begin
                        cur_next = in_entry;
                    end
                    if (load_count_reg == LAST_IDX)
                    begin
                        load_count_next = '0;
                        i_next          = '0;
                        j_next          = IW'(1);
                        state_next      = ST_SCAN;
                    end
                    else
                    begin
                        load_count_next = load_count_reg + 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                ram_rd_en       = 1'b1;
                proc_valid_next = 1'b1;
                proc_idx_next   = j_reg;
                if (j_reg == LAST_IDX)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    out_rank_next  = exsort_pkg::RANK_W'(i_reg) + 1'b1;
                    out_entry_next = cur_reg;
                    out_last_next  = (i_reg == EMIT_LAST);
                    if (i_reg == EMIT_LAST)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        i_next   = i_reg + 1'b1;
                        j_next   = i_reg + IW'(2);
                        cur_next = nxt_reg;
                        // The final slot needs no scan.
                        if (i_reg + 1'b1 == LAST_IDX)
                        begin
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            proc_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            proc_valid_reg <= proc_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        proc_idx_reg  <= proc_idx_next;
        cur_reg       <= cur_next;
        nxt_reg       <= nxt_next;
        out_rank_reg  <= out_rank_next;
        out_entry_reg <= out_entry_next;
        out_last_reg  <= out_last_next;
    end

    // Output stream.
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = exsort_pkg::M_DATA_W'({out_entry_reg, out_rank_reg});

    // A scan always reads a slot after slot i.
    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (j_reg > i_reg))
        else $error("scan index not beyond current slot");

    // The flush cycle always finishes the read of the final slot.
    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> (proc_valid_reg && proc_idx_reg == LAST_IDX))
        else $error("flush without pending final compare");

    // No compare is pending while entries are loading.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> !proc_valid_reg)
        else $error("compare pending during load");

    // The final result of a batch carries the last rank.
    a_last_rank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |->
        (out_rank_reg == exsort_pkg::RANK_W'(exsort_pkg::EMIT_COUNT)))
        else $error("last flag on wrong rank");

    // Leaving the emit state for loading happens only after the final result.
    a_batch_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && state_next == ST_LOAD) |=> (m_tvalid && m_tlast))
        else $error("batch ended without final result");

endmodule
